// ===== design/fqd_pkg.sv =====
// shared constants, types and codes for the fifo queue with delete
package fqd_pkg;

    localparam int DEPTH       = 16;
    localparam int HANDLE_BITS = 32;
    localparam int CNT_W       = $clog2(DEPTH + 1);

    localparam int REQ_W    = 2;
    localparam int STATUS_W = 3;
    localparam int ITEM_W   = 32;
    localparam int OCC_W    = 5;

    typedef enum logic [REQ_W-1:0] {
        REQ_ENQUEUE = 2'd0,
        REQ_DEQUEUE = 2'd1,
        REQ_DELETE  = 2'd2,
        REQ_NONE    = 2'd3
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_NULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_FULL     = 3'd4
    } t_status;

    typedef logic [HANDLE_BITS-1:0] t_handle;

    // command broadcast to every cell in the chain
    typedef struct packed {
        logic    enq;
        logic    deq;
        logic    del;
        t_handle handle;
    } t_cell_cmd;

endpackage

// ===== design/fqd_cell.sv =====
// one storage cell of the queue: holds an entry, compares it, shifts toward the front
module fqd_cell (
    input  logic               i_clk,
    input  fqd_pkg::t_cell_cmd i_cmd,
    input  logic               i_occupied,
    input  logic               i_at_tail,
    input  logic               i_hit_prev,
    input  fqd_pkg::t_handle   i_next_entry,
    output logic               o_hit,
    output fqd_pkg::t_handle   o_entry
);

    fqd_pkg::t_handle r_entry;
    fqd_pkg::t_handle n_entry;
    logic             w_shift;

    // hit so far: an earlier cell matched or this one does
    assign o_hit   = i_hit_prev | (i_occupied & (r_entry == i_cmd.handle));
    assign o_entry = r_entry;

    // cells at or behind the removed position take their neighbor's entry
    assign w_shift = i_cmd.deq | (i_cmd.del & o_hit);

    always_comb begin
        n_entry = r_entry;
        if (i_cmd.enq && i_at_tail) begin
            n_entry = i_cmd.handle;
        end else if (w_shift) begin
            n_entry = i_next_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// ===== design/fifo_queue_with_delete_top.sv =====
// top level of the fifo queue with delete: request decode, occupancy count, cell chain, result register
//
// Bounded queue of 16 nonzero 32-bit handles held in a chain of cells, front in cell 0.
// Each request (enqueue, dequeue, delete first match) is decoded and applied combinationally; one request
// is accepted per clock while o_in_stall is low; its result appears in the output register on the next cycle.
// A new item is taken while a result waits as long as the downstream stall is low, so
// the result register is the only buffer. The delete match ripples through all cells
// combinationally, and that chain sets the clock path of the block.
module fifo_queue_with_delete_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [fqd_pkg::REQ_W-1:0]     i_req_type,
    input  logic [fqd_pkg::ITEM_W-1:0]    i_item_handle,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [fqd_pkg::STATUS_W-1:0]  o_status,
    output logic [fqd_pkg::ITEM_W-1:0]    o_item_out,
    output logic [fqd_pkg::OCC_W-1:0]     o_occupancy
);

    logic                       r_out_valid;
    logic                       n_out_valid;
    fqd_pkg::t_status           r_status;
    fqd_pkg::t_status           n_status;
    logic [fqd_pkg::ITEM_W-1:0] r_item_out;
    logic [fqd_pkg::ITEM_W-1:0] n_item_out;
    logic [fqd_pkg::CNT_W-1:0]  r_count;
    logic [fqd_pkg::CNT_W-1:0]  n_count;

    logic                       w_accept;
    fqd_pkg::t_req              w_req;
    fqd_pkg::t_handle           w_handle;
    logic                       w_null;
    logic                       w_empty;
    logic                       w_full;
    logic                       w_found;
    fqd_pkg::t_cell_cmd         w_cmd;

    fqd_pkg::t_handle           w_entry [fqd_pkg::DEPTH];
    logic                       w_hit   [fqd_pkg::DEPTH+1];

    assign o_in_stall = r_out_valid & i_out_stall;
    assign w_accept   = i_in_valid & ~o_in_stall;

    assign w_req    = fqd_pkg::t_req'(i_req_type);
    assign w_handle = i_item_handle[fqd_pkg::HANDLE_BITS-1:0];
    assign w_null   = (w_handle == '0);
    assign w_empty  = (r_count == '0);
    assign w_full   = (r_count >= fqd_pkg::CNT_W'(fqd_pkg::DEPTH));
    assign w_found  = w_hit[fqd_pkg::DEPTH];

    assign w_hit[0] = 1'b0;

    // commands only fire when the null, empty and full checks pass; a delete that matches no cell shifts nothing
    always_comb begin
        w_cmd.handle = w_handle;
        w_cmd.enq    = w_accept & (w_req == fqd_pkg::REQ_ENQUEUE) & ~w_null & ~w_full;
        w_cmd.deq    = w_accept & (w_req == fqd_pkg::REQ_DEQUEUE) & ~w_empty;
        w_cmd.del    = w_accept & (w_req == fqd_pkg::REQ_DELETE) & ~w_null & ~w_empty;
    end

    genvar g;
    generate
        for (g = 0; g < fqd_pkg::DEPTH; g++) begin : g_cell
            fqd_pkg::t_handle w_next;
            if (g == fqd_pkg::DEPTH - 1) begin : g_last
                assign w_next = w_entry[g];
            end else begin : g_mid
                assign w_next = w_entry[g+1];
            end

            fqd_cell u_cell (
                .i_clk        (i_clk),
                .i_cmd        (w_cmd),
                .i_occupied   (r_count > fqd_pkg::CNT_W'(g)),
                .i_at_tail    (r_count == fqd_pkg::CNT_W'(g)),
                .i_hit_prev   (w_hit[g]),
                .i_next_entry (w_next),
                .o_hit        (w_hit[g+1]),
                .o_entry      (w_entry[g])
            );
        end
    endgenerate

    always_comb begin
        n_count    = r_count;
        n_status   = fqd_pkg::ST_OK;
        n_item_out = '0;
        case (w_req)
            fqd_pkg::REQ_ENQUEUE: begin
                if (w_null) begin
                    n_status = fqd_pkg::ST_NULL;
                end else if (w_full) begin
                    n_status = fqd_pkg::ST_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            fqd_pkg::REQ_DEQUEUE: begin
                if (w_empty) begin
                    n_status = fqd_pkg::ST_EMPTY;
                end else begin
                    n_item_out = fqd_pkg::ITEM_W'(w_entry[0]);
                    n_count    = r_count - 1'b1;
                end
            end
            fqd_pkg::REQ_DELETE: begin
                if (w_null) begin
                    n_status = fqd_pkg::ST_NULL;
                end else if (w_empty) begin
                    n_status = fqd_pkg::ST_EMPTY;
                end else if (!w_found) begin
                    n_status = fqd_pkg::ST_NOTFOUND;
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_accept) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            if (w_accept) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status   <= n_status;
            r_item_out <= n_item_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_item_out  = r_item_out;
    assign o_occupancy = fqd_pkg::OCC_W'(r_count);

endmodule
